// ===== src/cpb_pkg.sv =====
package cpb_pkg;

	localparam int COORD_BITS  = 12;
	localparam int SIZE_BITS   = COORD_BITS - 1;
	localparam int EXT_BITS    = COORD_BITS + 1;
	localparam int DIFF_BITS   = COORD_BITS + 2;
	localparam int COLOR_BITS  = 16;
	localparam int IDX_BITS    = 8;
	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
	localparam int CFG_AW      = 3;
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	typedef enum logic [1:0] {
		OP_PAL_WRITE = 2'd0,
		OP_START     = 2'd1,
		OP_PIXEL     = 2'd2,
		OP_UNUSED    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_PAL        = 2'd0,
		MODE_PAL_TRANSP = 2'd1,
		MODE_REPLACE    = 2'd2,
		MODE_DIRECT     = 2'd3
	} mode_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_WIN_LEFT       = 3'd0,
		REG_WIN_TOP        = 3'd1,
		REG_WIN_WIDTH      = 3'd2,
		REG_WIN_HEIGHT     = 3'd3,
		REG_SRC_BUF_WIDTH  = 3'd4,
		REG_SRC_BUF_HEIGHT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]                   op;
		logic signed [COORD_BITS-1:0] dst_x;
		logic signed [COORD_BITS-1:0] dst_y;
		logic signed [COORD_BITS-1:0] src_x;
		logic signed [COORD_BITS-1:0] src_y;
		logic [SIZE_BITS-1:0]         rect_width;
		logic [SIZE_BITS-1:0]         rect_height;
		logic [1:0]                   mode;
		logic [COLOR_BITS-1:0]        fg_color;
		logic [COLOR_BITS-1:0]        bg_color;
		logic [COLOR_BITS-1:0]        pixel_value;
		logic [IDX_BITS-1:0]          palette_index;
	} req_t;

	typedef struct packed {
		logic                         kind;
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic signed [COORD_BITS-1:0] out_src_x;
		logic signed [COORD_BITS-1:0] out_src_y;
		logic [SIZE_BITS-1:0]         out_width;
		logic [SIZE_BITS-1:0]         out_height;
		logic [COLOR_BITS-1:0]        color;
		logic                         write_enable;
		logic                         last;
		logic                         empty_res;
	} res_t;

	// classified command between front and back
	typedef struct packed {
		logic [1:0]                   op;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] sx;
		logic signed [COORD_BITS-1:0] sy;
		logic [SIZE_BITS-1:0]         w;
		logic [SIZE_BITS-1:0]         h;
		logic                         empty;
		logic [1:0]                   mode;
		logic [COLOR_BITS-1:0]        fg;
		logic [COLOR_BITS-1:0]        bg;
		logic [COLOR_BITS-1:0]        pixel_value;
		logic [IDX_BITS-1:0]          palette_index;
	} cmd_t;

endpackage

// ===== src/clipped_palette_blit_core.sv =====
// palette blitter with destination-window clipping
// request channel (req_valid/req_ready/req_data) takes three kinds of request:
// palette entry writes, blit starts and source pixels in row-major order.
// a start yields one region report (kind 0); each source pixel of an active
// blit yields one pixel write (kind 1) on res_valid/res_ready/res_data.
// palette writes, stray pixels and unknown ops yield nothing.
// window and source buffer registers are written through cfg_we/cfg_index/
// cfg_wdata; the user must write them only while no request is in flight,
// the block itself does not enforce this. a request passes the two clip stages,
// the queue and the output register with the palette read before its result shows.
// throughput: one request per cycle while the receiver does not stall.
// a four-entry queue sits between the clip front end and the back end; when
// the receiver stalls, requests keep flowing in until the two clip stages,
// the queue and the output register are full, then req_ready drops.
// reset clears all control state and the window registers (window 320x240
// at origin); palette contents stay undefined until written.
module clipped_palette_blit_core import cpb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_AW-1:0]     cfg_index,
	input  logic [COORD_BITS-1:0] cfg_wdata,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res_data
);

	logic push, push_ready, pop_valid, pop;
	cmd_t push_data, pop_data;

	cpb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.push      (push),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	cpb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data)
	);

	cpb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop      (pop),
		.pop_data (pop_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

endmodule

// ===== src/cpb_ram.sv =====
module cpb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/cpb_front.sv =====
module cpb_front import cpb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_AW-1:0]     cfg_index,
	input  logic [COORD_BITS-1:0] cfg_wdata,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req_data,
	output logic                  push,
	input  logic                  push_ready,
	output cmd_t                  push_data
);

	typedef struct packed {
		logic [1:0]                   op;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] sx;
		logic signed [COORD_BITS-1:0] sy;
		logic signed [EXT_BITS-1:0]   x_end;
		logic signed [EXT_BITS-1:0]   y_end;
		logic signed [EXT_BITS-1:0]   dlt_x;
		logic signed [EXT_BITS-1:0]   dlt_y;
		logic                         clip_left;
		logic                         clip_top;
		logic [1:0]                   mode;
		logic [COLOR_BITS-1:0]        fg;
		logic [COLOR_BITS-1:0]        bg;
		logic [COLOR_BITS-1:0]        pixel_value;
		logic [IDX_BITS-1:0]          palette_index;
	} clip_t;

	logic signed [COORD_BITS-1:0] win_left_q, win_top_q;
	logic [SIZE_BITS-1:0]         win_width_q, win_height_q;
	logic [SIZE_BITS-1:0]         src_buf_width_q, src_buf_height_q;

	logic  v_s1, v_s2;
	req_t  req_s1;
	clip_t clip_s2;
	clip_t clip_n;
	logic  s2_free;

	logic [SIZE_BITS-1:0]       w_eff, h_eff;
	logic signed [EXT_BITS-1:0] dx_e, dy_e, wl_e, wt_e;
	logic signed [EXT_BITS-1:0] dx1, dy1, wx1, wy1;
	logic signed [EXT_BITS-1:0] dlt_x, dlt_y;
	logic signed [DIFF_BITS-1:0] cw, ch;
	logic                        cw_le0, ch_le0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q       <= '0;
			win_top_q        <= '0;
			win_width_q      <= SIZE_BITS'(320);
			win_height_q     <= SIZE_BITS'(240);
			src_buf_width_q  <= SIZE_BITS'(320);
			src_buf_height_q <= SIZE_BITS'(240);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIN_LEFT:       win_left_q       <= cfg_wdata;
				REG_WIN_TOP:        win_top_q        <= cfg_wdata;
				REG_WIN_WIDTH:      win_width_q      <= cfg_wdata[SIZE_BITS-1:0];
				REG_WIN_HEIGHT:     win_height_q     <= cfg_wdata[SIZE_BITS-1:0];
				REG_SRC_BUF_WIDTH:  src_buf_width_q  <= cfg_wdata[SIZE_BITS-1:0];
				REG_SRC_BUF_HEIGHT: src_buf_height_q <= cfg_wdata[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign s2_free   = !v_s2 || push_ready;
	assign req_ready = !v_s1 || s2_free;
	assign push      = v_s2;

	// first half of the clip: corner ends, window ends, left/top cut
	always_comb begin
		w_eff = req_s1.rect_width;
		h_eff = req_s1.rect_height;
		if (req_s1.mode == MODE_DIRECT) begin
			if (req_s1.rect_width == '0) w_eff = src_buf_width_q;
			if (req_s1.rect_height == '0) h_eff = src_buf_height_q;
		end
		dx_e  = {req_s1.dst_x[COORD_BITS-1], req_s1.dst_x};
		dy_e  = {req_s1.dst_y[COORD_BITS-1], req_s1.dst_y};
		wl_e  = {win_left_q[COORD_BITS-1], win_left_q};
		wt_e  = {win_top_q[COORD_BITS-1], win_top_q};
		dx1   = dx_e + {2'b00, w_eff};
		dy1   = dy_e + {2'b00, h_eff};
		wx1   = wl_e + {2'b00, win_width_q};
		wy1   = wt_e + {2'b00, win_height_q};
		dlt_x = wl_e - dx_e;
		dlt_y = wt_e - dy_e;

		clip_n.op            = req_s1.op;
		clip_n.clip_left     = !dlt_x[EXT_BITS-1] && (dlt_x != '0);
		clip_n.clip_top      = !dlt_y[EXT_BITS-1] && (dlt_y != '0);
		clip_n.x             = clip_n.clip_left ? win_left_q : req_s1.dst_x;
		clip_n.y             = clip_n.clip_top ? win_top_q : req_s1.dst_y;
		clip_n.sx            = req_s1.src_x;
		clip_n.sy            = req_s1.src_y;
		clip_n.x_end         = (dx1 > wx1) ? wx1 : dx1;
		clip_n.y_end         = (dy1 > wy1) ? wy1 : dy1;
		clip_n.dlt_x         = dlt_x;
		clip_n.dlt_y         = dlt_y;
		clip_n.mode          = req_s1.mode;
		clip_n.fg            = req_s1.fg_color;
		clip_n.bg            = req_s1.bg_color;
		clip_n.pixel_value   = req_s1.pixel_value;
		clip_n.palette_index = req_s1.palette_index;
	end

	// second half: clipped size, moved source corner
	always_comb begin
		cw = {clip_s2.x_end[EXT_BITS-1], clip_s2.x_end}
			- {{2{clip_s2.x[COORD_BITS-1]}}, clip_s2.x};
		ch = {clip_s2.y_end[EXT_BITS-1], clip_s2.y_end}
			- {{2{clip_s2.y[COORD_BITS-1]}}, clip_s2.y};
		cw_le0 = cw[DIFF_BITS-1] || (cw == '0);
		ch_le0 = ch[DIFF_BITS-1] || (ch == '0);

		push_data.op            = clip_s2.op;
		push_data.x             = clip_s2.x;
		push_data.y             = clip_s2.y;
		push_data.sx            = clip_s2.sx
			+ (clip_s2.clip_left ? clip_s2.dlt_x[COORD_BITS-1:0] : '0);
		push_data.sy            = clip_s2.sy
			+ (clip_s2.clip_top ? clip_s2.dlt_y[COORD_BITS-1:0] : '0);
		push_data.w             = cw_le0 ? '0 : cw[SIZE_BITS-1:0];
		push_data.h             = ch_le0 ? '0 : ch[SIZE_BITS-1:0];
		push_data.empty         = cw_le0 || ch_le0;
		push_data.mode          = clip_s2.mode;
		push_data.fg            = clip_s2.fg;
		push_data.bg            = clip_s2.bg;
		push_data.pixel_value   = clip_s2.pixel_value;
		push_data.palette_index = clip_s2.palette_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				// unknown op is taken and dropped here
				v_s1 <= req_valid && (req_data.op != OP_UNUSED);
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_data;
		end
		if (s2_free && v_s1) begin
			clip_s2 <= clip_n;
		end
	end

endmodule

// ===== src/cpb_queue.sv =====
module cpb_queue import cpb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop,
	output cmd_t pop_data
);

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push, do_pop;

	assign push_ready = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// a request offered to a full queue waits unchanged
	a_push_held: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !push_ready) |=> (push && $stable(push_data)))
		else $error("request dropped or changed while queue full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("request popped from empty queue");

endmodule

// ===== src/cpb_back.sv =====
module cpb_back import cpb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop,
	input  cmd_t pop_data,
	output logic res_valid,
	input  logic res_ready,
	output res_t res_data
);

	logic                         active_q;
	logic signed [COORD_BITS-1:0] base_x_q, base_y_q;
	logic [SIZE_BITS-1:0]         span_w_q, span_h_q, col_q, row_q;
	logic [1:0]                   mode_q;
	logic [COLOR_BITS-1:0]        fore_q, back_q;

	logic res_valid_q, use_pal_q;
	res_t res_q;

	logic [SIZE_BITS:0]    col_inc, row_inc;
	logic                  col_end, row_end, fin;
	logic [COLOR_BITS-1:0] pv;
	logic                  pal_oob, pix_use_pal;
	res_t                  pix_res, start_res;
	logic                  ram_we, ram_re;
	logic [COLOR_BITS-1:0] ram_rdata;

	assign pop = pop_valid && (!res_valid_q || res_ready);

	always_comb begin
		pv      = pop_data.pixel_value;
		pal_oob = 32'(pv) >= 32'(PAL_ENTRIES);
		col_inc = {1'b0, col_q} + 1'b1;
		row_inc = {1'b0, row_q} + 1'b1;
		col_end = col_inc >= {1'b0, span_w_q};
		row_end = row_inc >= {1'b0, span_h_q};
		fin     = col_end && row_end;

		pix_res              = '0;
		pix_res.kind         = 1'b1;
		pix_res.out_x        = base_x_q + {1'b0, col_q};
		pix_res.out_y        = base_y_q + {1'b0, row_q};
		pix_res.write_enable = 1'b1;
		pix_res.last         = fin;
		pix_use_pal          = 1'b0;
		case (mode_q)
			MODE_PAL: begin
				pix_use_pal = !pal_oob;
			end
			MODE_PAL_TRANSP: begin
				// index zero is a transparent skip
				if (pv == '0) begin
					pix_res.write_enable = 1'b0;
				end else begin
					pix_use_pal = !pal_oob;
				end
			end
			MODE_REPLACE: begin
				pix_res.color = (pv != '0) ? fore_q : back_q;
			end
			default: begin
				pix_res.color = pv;
			end
		endcase

		start_res            = '0;
		start_res.out_x      = pop_data.x;
		start_res.out_y      = pop_data.y;
		start_res.out_src_x  = pop_data.sx;
		start_res.out_src_y  = pop_data.sy;
		start_res.out_width  = pop_data.w;
		start_res.out_height = pop_data.h;
		start_res.empty_res  = pop_data.empty;

		ram_we = pop && (pop_data.op == OP_PAL_WRITE)
			&& ({1'b0, pop_data.palette_index} < (IDX_BITS+1)'(PAL_ENTRIES));
		ram_re = pop && (pop_data.op == OP_PIXEL) && active_q && pix_use_pal;
	end

	cpb_ram #(
		.WIDTH(COLOR_BITS),
		.DEPTH(PAL_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pop_data.palette_index[PAL_AW-1:0]),
		.wdata(pv),
		.re   (ram_re),
		.raddr(pv[PAL_AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			use_pal_q   <= 1'b0;
			active_q    <= 1'b0;
			base_x_q    <= '0;
			base_y_q    <= '0;
			span_w_q    <= '0;
			span_h_q    <= '0;
			col_q       <= '0;
			row_q       <= '0;
			mode_q      <= '0;
			fore_q      <= '0;
			back_q      <= '0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop) begin
				case (pop_data.op)
					OP_START: begin
						// a restart abandons any blit in flight
						active_q    <= !pop_data.empty;
						base_x_q    <= pop_data.x;
						base_y_q    <= pop_data.y;
						span_w_q    <= pop_data.w;
						span_h_q    <= pop_data.h;
						col_q       <= '0;
						row_q       <= '0;
						mode_q      <= pop_data.mode;
						fore_q      <= pop_data.fg;
						back_q      <= pop_data.bg;
						res_valid_q <= 1'b1;
						use_pal_q   <= 1'b0;
					end
					OP_PIXEL: begin
						if (active_q) begin
							res_valid_q <= 1'b1;
							use_pal_q   <= pix_use_pal;
							if (fin) begin
								active_q <= 1'b0;
								col_q    <= '0;
								row_q    <= '0;
							end else if (col_end) begin
								col_q <= '0;
								row_q <= row_inc[SIZE_BITS-1:0];
							end else begin
								col_q <= col_inc[SIZE_BITS-1:0];
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (pop_data.op == OP_START)) begin
			res_q <= start_res;
		end else if (pop && (pop_data.op == OP_PIXEL) && active_q) begin
			res_q <= pix_res;
		end
	end

	always_comb begin
		res_data = res_q;
		if (use_pal_q) begin
			res_data.color = ram_rdata;
		end
	end

	assign res_valid = res_valid_q;

	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> ((span_w_q != '0) && (span_h_q != '0)))
		else $error("blit running over an empty region");

	a_count_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> ((col_q < span_w_q) && (row_q < span_h_q)))
		else $error("pixel position left the clipped region");

	a_read_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> (res_valid_q && use_pal_q))
		else $error("palette read without a pending pixel result");

endmodule

// ===== tb/cpb_checker.sv =====
`timescale 1ns / 100ps

module cpb_checker import cpb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_AW-1:0]     cfg_index,
	input  logic [COORD_BITS-1:0] cfg_wdata,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  req_t                  req_data,
	input  logic                  res_valid,
	input  logic                  res_ready,
	input  res_t                  res_data,
	output int                    mismatches,
	output int                    owed_count
);

	localparam logic KIND_REGION = 1'b0;
	localparam logic KIND_WRITE  = 1'b1;
	localparam int   PRINT_CAP   = 40;

	logic [COLOR_BITS-1:0]        pal_mem [PAL_ENTRIES];
	logic signed [COORD_BITS-1:0] win_left;
	logic signed [COORD_BITS-1:0] win_top;
	logic [SIZE_BITS-1:0]         win_width;
	logic [SIZE_BITS-1:0]         win_height;
	logic [SIZE_BITS-1:0]         sbuf_width;
	logic [SIZE_BITS-1:0]         sbuf_height;

	logic                  busy;
	int                    base_x;
	int                    base_y;
	int                    span_w;
	int                    span_h;
	int                    col;
	int                    row;
	mode_t                 paint_mode;
	logic [COLOR_BITS-1:0] fore;
	logic [COLOR_BITS-1:0] back;

	res_t owed[$];
	res_t want;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input longint got, input longint exp_v);
		if (got != exp_v)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, exp_v));
	endtask

	function automatic logic [COLOR_BITS-1:0] pal_lookup(input logic [COLOR_BITS-1:0] idx);
		if (idx >= PAL_ENTRIES)
			return '0;
		return pal_mem[idx[IDX_BITS-1:0]];
	endfunction

	// clip against the window, shift the source corner by what was cut
	task automatic predict_start(input req_t r);
		int   dx, dy, sx, sy, w, h, dx1, dy1, wx1, wy1, cw, ch;
		logic no_pixels;
		res_t e;
		dx = int'($signed(r.dst_x));
		dy = int'($signed(r.dst_y));
		sx = int'($signed(r.src_x));
		sy = int'($signed(r.src_y));
		w  = int'(r.rect_width);
		h  = int'(r.rect_height);
		if (r.mode == MODE_DIRECT) begin
			if (w == 0)
				w = int'(sbuf_width);
			if (h == 0)
				h = int'(sbuf_height);
		end
		wx1 = int'(win_left) + int'(win_width);
		wy1 = int'(win_top) + int'(win_height);
		dx1 = dx + w;
		dy1 = dy + h;
		if (dx < int'(win_left)) begin
			sx = sx + int'(win_left) - dx;
			dx = int'(win_left);
		end
		if (dx1 > wx1)
			dx1 = wx1;
		if (dy < int'(win_top)) begin
			sy = sy + int'(win_top) - dy;
			dy = int'(win_top);
		end
		if (dy1 > wy1)
			dy1 = wy1;
		cw = dx1 - dx;
		ch = dy1 - dy;
		no_pixels = (cw <= 0) || (ch <= 0);
		if (cw < 0)
			cw = 0;
		if (ch < 0)
			ch = 0;

		e = '0;
		e.kind       = KIND_REGION;
		e.out_x      = dx[COORD_BITS-1:0];
		e.out_y      = dy[COORD_BITS-1:0];
		e.out_src_x  = sx[COORD_BITS-1:0];
		e.out_src_y  = sy[COORD_BITS-1:0];
		e.out_width  = cw[SIZE_BITS-1:0];
		e.out_height = ch[SIZE_BITS-1:0];
		e.empty_res  = no_pixels;
		owed.push_back(e);

		busy       = !no_pixels;
		base_x     = dx;
		base_y     = dy;
		span_w     = cw & ((1 << SIZE_BITS) - 1);
		span_h     = ch & ((1 << SIZE_BITS) - 1);
		col        = 0;
		row        = 0;
		paint_mode = mode_t'(r.mode);
		fore       = r.fg_color;
		back       = r.bg_color;
	endtask

	task automatic predict_pixel(input req_t r);
		logic [COLOR_BITS-1:0] pv;
		logic [COLOR_BITS-1:0] c;
		logic                  we;
		logic                  fin;
		int                    px, py;
		res_t                  e;
		if (!busy)
			return;
		pv = r.pixel_value;
		c  = '0;
		we = 1'b1;
		case (paint_mode)
			MODE_PAL: c = pal_lookup(pv);
			MODE_PAL_TRANSP: begin
				if (pv == '0)
					we = 1'b0;
				else
					c = pal_lookup(pv);
			end
			MODE_REPLACE: c = (pv != '0) ? fore : back;
			default: c = pv;
		endcase
		fin = (col + 1 >= span_w) && (row + 1 >= span_h);
		px  = base_x + col;
		py  = base_y + row;

		e = '0;
		e.kind         = KIND_WRITE;
		e.out_x        = px[COORD_BITS-1:0];
		e.out_y        = py[COORD_BITS-1:0];
		e.color        = c;
		e.write_enable = we;
		e.last         = fin;
		owed.push_back(e);

		if (fin) begin
			busy = 1'b0;
			col  = 0;
			row  = 0;
		end else if (col + 1 >= span_w) begin
			col = 0;
			row = row + 1;
		end else begin
			col = col + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left    = '0;
			win_top     = '0;
			win_width   = 11'd320;
			win_height  = 11'd240;
			sbuf_width  = 11'd320;
			sbuf_height = 11'd240;
			busy        = 1'b0;
			base_x      = 0;
			base_y      = 0;
			span_w      = 0;
			span_h      = 0;
			col         = 0;
			row         = 0;
			paint_mode  = MODE_PAL;
			fore        = '0;
			back        = '0;
			owed.delete();
			mismatches  = 0;
			owed_count  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WIN_LEFT:       win_left    = cfg_wdata;
					REG_WIN_TOP:        win_top     = cfg_wdata;
					REG_WIN_WIDTH:      win_width   = cfg_wdata[SIZE_BITS-1:0];
					REG_WIN_HEIGHT:     win_height  = cfg_wdata[SIZE_BITS-1:0];
					REG_SRC_BUF_WIDTH:  sbuf_width  = cfg_wdata[SIZE_BITS-1:0];
					REG_SRC_BUF_HEIGHT: sbuf_height = cfg_wdata[SIZE_BITS-1:0];
					default: ;
				endcase
			end

			// the request is applied first: a result can never belong to a later request
			if (req_valid && req_ready) begin
				case (req_data.op)
					OP_PAL_WRITE: pal_mem[req_data.palette_index] = req_data.pixel_value;
					OP_START:     predict_start(req_data);
					OP_PIXEL:     predict_pixel(req_data);
					default: ;
				endcase
			end

			if (res_valid && res_ready) begin
				if (owed.size() == 0) begin
					report_mismatch($sformatf("result with nothing owed, kind %0d",
						res_data.kind));
				end else begin
					want = owed.pop_front();
					check_field("kind", res_data.kind, want.kind);
					check_field("out_x", res_data.out_x, want.out_x);
					check_field("out_y", res_data.out_y, want.out_y);
					check_field("out_src_x", res_data.out_src_x, want.out_src_x);
					check_field("out_src_y", res_data.out_src_y, want.out_src_y);
					check_field("out_width", res_data.out_width, want.out_width);
					check_field("out_height", res_data.out_height, want.out_height);
					check_field("color", res_data.color, want.color);
					check_field("write_enable", res_data.write_enable, want.write_enable);
					check_field("last", res_data.last, want.last);
					check_field("empty_res", res_data.empty_res, want.empty_res);
				end
			end
			owed_count = owed.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import cpb_pkg::*;

	localparam int         CYCLE_LIMIT = 400000;
	localparam int         MAX_WAIT    = 18;
	localparam int         PHASE_ITEMS = 150;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_AW-1:0]     cfg_index;
	logic [COORD_BITS-1:0] cfg_wdata;
	logic                  req_valid;
	logic                  req_ready;
	req_t                  req_data;
	logic                  res_valid;
	logic                  res_ready;
	res_t                  res_data;
	int                    mismatches;
	int                    owed_count;

	int    cycles = 0;
	int    sent = 0;
	int    win_l, win_t, win_w, win_h, sb_w, sb_h;
	mode_t cur_mode;
	bit    pal_known [PAL_ENTRIES];
	int    known_idx[$];
	bit    steady_tx = 1'b0;
	bit    steady_rx = 1'b0;

	always #4 clk = ~clk;

	clipped_palette_blit_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	cpb_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_data   (req_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.mismatches (mismatches),
		.owed_count (owed_count)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: random stall before each result, with stall-free stretches
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				steady_rx = !steady_rx;
			stall = steady_rx ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!(res_valid && res_ready));
		end
	end

	function automatic req_t random_req();
		req_t r;
		r.op            = 2'($urandom);
		r.dst_x         = 12'($urandom);
		r.dst_y         = 12'($urandom);
		r.src_x         = 12'($urandom);
		r.src_y         = 12'($urandom);
		r.rect_width    = 11'($urandom);
		r.rect_height   = 11'($urandom);
		r.mode          = 2'($urandom);
		r.fg_color      = 16'($urandom);
		r.bg_color      = 16'($urandom);
		r.pixel_value   = 16'($urandom);
		r.palette_index = 8'($urandom);
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send(input req_t r);
		int gap;
		if ($urandom_range(0, 39) == 0)
			steady_tx = !steady_tx;
		gap = steady_tx ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (!(req_valid && req_ready));
		@(negedge clk);
		sent++;
		if (r.op == OP_PAL_WRITE && !pal_known[r.palette_index]) begin
			pal_known[r.palette_index] = 1'b1;
			known_idx.push_back(r.palette_index);
		end
		if (r.op == OP_START)
			cur_mode = mode_t'(r.mode);
	endtask

	task automatic write_entry(input logic [IDX_BITS-1:0] idx, input logic [COLOR_BITS-1:0] v);
		req_t r;
		r = random_req();
		r.op            = OP_PAL_WRITE;
		r.palette_index = idx;
		r.pixel_value   = v;
		send(r);
	endtask

	task automatic send_pixel_value(input logic [COLOR_BITS-1:0] v);
		req_t r;
		r = random_req();
		r.op          = OP_PIXEL;
		r.pixel_value = v;
		send(r);
	endtask

	task automatic start_blit(input int dx, dy, sx, sy, w, h, input mode_t m,
		input logic [COLOR_BITS-1:0] fg, bg);
		req_t r;
		r = random_req();
		r.op          = OP_START;
		r.dst_x       = 12'(dx);
		r.dst_y       = 12'(dy);
		r.src_x       = 12'(sx);
		r.src_y       = 12'(sy);
		r.rect_width  = 11'(w);
		r.rect_height = 11'(h);
		r.mode        = m;
		r.fg_color    = fg;
		r.bg_color    = bg;
		send(r);
	endtask

	// palette modes only ever read entries that have been loaded
	function automatic logic [COLOR_BITS-1:0] pick_pixel_value();
		int k;
		k = $urandom_range(0, 9);
		if (cur_mode == MODE_REPLACE || cur_mode == MODE_DIRECT)
			return (k < 3) ? '0 : 16'($urandom);
		if (k == 9 && cur_mode == MODE_PAL_TRANSP)
			return '0;
		if (k >= 7)
			return 16'($urandom_range(PAL_ENTRIES, 65535));
		return 16'(known_idx[$urandom_range(0, known_idx.size() - 1)]);
	endfunction

	// half of the corners straddle a window edge so clipping is exercised
	function automatic logic [COORD_BITS-1:0] pick_corner(input int lo, input int span);
		int v;
		case ($urandom_range(0, 9))
			0:       v = $urandom;
			1, 2, 3: v = lo - 8 + int'($urandom_range(0, 12));
			4, 5:    v = lo + span - 8 + int'($urandom_range(0, 10));
			default: v = lo + int'($urandom_range(0, (span < 40) ? span : 40));
		endcase
		return v[COORD_BITS-1:0];
	endfunction

	function automatic logic [SIZE_BITS-1:0] pick_size(input int typ_max);
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return 11'($urandom);
			default: return 11'($urandom_range(1, typ_max));
		endcase
	endfunction

	task automatic send_noise();
		req_t r;
		r = random_req();
		if ($urandom_range(0, 2) == 0)
			r.op = OP_UNUSED;
		else
			r.op = OP_PAL_WRITE;
		send(r);
	endtask

	task automatic run_blit();
		req_t r;
		int   ew, eh, n;
		r = random_req();
		r.op          = OP_START;
		r.dst_x       = pick_corner(win_l, win_w);
		r.dst_y       = pick_corner(win_t, win_h);
		r.rect_width  = pick_size(8);
		r.rect_height = pick_size(6);
		send(r);
		ew = (r.mode == MODE_DIRECT && r.rect_width == '0) ? sb_w : int'(r.rect_width);
		eh = (r.mode == MODE_DIRECT && r.rect_height == '0) ? sb_h : int'(r.rect_height);
		n  = ew * eh;
		if (n > 48)
			n = $urandom_range(1, 48);
		// sometimes cut short so the next start abandons the blit
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(0, n);
		repeat (n) begin
			if ($urandom_range(0, 29) == 0)
				send_noise();
			send_pixel_value(pick_pixel_value());
		end
	endtask

	task automatic random_phase(input int budget);
		int stop;
		stop = sent + budget;
		while (sent < stop) begin
			case ($urandom_range(0, 19))
				0, 1:    write_entry(8'($urandom), 16'($urandom));
				2:       send_noise();
				3:       send_pixel_value(pick_pixel_value());
				default: run_blit();
			endcase
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input int v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v[COORD_BITS-1:0];
		@(negedge clk);
	endtask

	task automatic set_window(input int l, t, w, h, sw, sh);
		req_valid <= 1'b0;
		while (owed_count != 0) @(negedge clk);
		// palette writes and stray pixels may still be in the pipe
		repeat (8) @(negedge clk);
		write_reg(REG_WIN_LEFT, l);
		write_reg(REG_WIN_TOP, t);
		write_reg(REG_WIN_WIDTH, w);
		write_reg(REG_WIN_HEIGHT, h);
		write_reg(REG_SRC_BUF_WIDTH, sw);
		write_reg(REG_SRC_BUF_HEIGHT, sh);
		cfg_we <= 1'b0;
		win_l = l;
		win_t = t;
		win_w = w;
		win_h = h;
		sb_w  = sw;
		sb_h  = sh;
	endtask

	task automatic directed();
		write_entry(8'h00, 16'hFFFF);
		write_entry(8'hFF, 16'h0000);
		write_entry(8'h55, 16'hA5A5);
		send_noise();
		send_pixel_value(16'h0055);
		// top-left overhang clipped down to one pixel
		start_blit(-3, -2, 5, 6, 4, 3, MODE_PAL, '0, '0);
		send_pixel_value(16'h00FF);
		start_blit(10, 10, 0, 0, 2, 1, MODE_PAL_TRANSP, '0, '0);
		send_pixel_value(16'h0000);
		send_pixel_value(16'h0055);
		// bottom-right overhang
		start_blit(318, 239, 1, 1, 3, 1, MODE_REPLACE, 16'hFFFF, 16'h0001);
		send_pixel_value(16'h0000);
		send_pixel_value(16'hFFFF);
		// zero size copies the source buffer, abandoned by the next start
		start_blit(0, 0, 0, 0, 0, 0, MODE_DIRECT, '0, '0);
		send_pixel_value(16'h1234);
		send_pixel_value(16'hFFFF);
		start_blit(5, 5, 0, 0, 1, 1, MODE_PAL, '0, '0);
		send_pixel_value(16'h0100);
		start_blit(2047, 2047, 0, 0, 2047, 2047, MODE_PAL, '0, '0);
		// source corner wraps after the left/top cut
		start_blit(-2048, -2048, 2047, 2047, 2047, 2047, MODE_DIRECT, 16'hFFFF, 16'hFFFF);
		start_blit(0, 0, 0, 0, 0, 5, MODE_PAL, '0, '0);
		send_pixel_value(16'h0000);
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_WIN_LEFT;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req_data  = '0;
		res_ready = 1'b0;
		win_l     = 0;
		win_t     = 0;
		win_w     = 320;
		win_h     = 240;
		sb_w      = 320;
		sb_h      = 240;
		cur_mode  = MODE_PAL;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed();
		random_phase(PHASE_ITEMS);
		set_window(0, 0, 16, 12, 5, 3);
		random_phase(PHASE_ITEMS);
		set_window(-2048, -2048, 2047, 2047, 0, 0);
		random_phase(PHASE_ITEMS);
		set_window(2047, 2047, 2047, 2047, 2047, 2047);
		random_phase(PHASE_ITEMS);
		set_window(-5, 7, 0, 0, 7, 2);
		random_phase(PHASE_ITEMS / 2);
		repeat (3) begin
			set_window(int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100,
				$urandom_range(1, 40), $urandom_range(1, 30),
				$urandom_range(1, 9), $urandom_range(1, 6));
			random_phase(PHASE_ITEMS);
		end

		req_valid <= 1'b0;
		while (owed_count != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
